>>> rtl/a2b_pkg.sv
package a2b_pkg;

   // width of the unit byte count that the parser looks at
   localparam int UNIT_COUNT_BITS = 24;

   // command queue between parser and expander
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // record header: first byte value, minimum length, sps count position
   localparam logic [7:0] RECORD_VERSION = 8'd1;
   localparam int         RECORD_MIN_LEN = 7;
   localparam logic [2:0] HDR_COUNT_POS  = 3'd5;
   localparam logic [7:0] SPS_COUNT_MASK = 8'h1f;

   // sample length field: four bytes, the last start-code byte is 1
   localparam logic [2:0] LEN_FIELD_BYTES = 3'd4;
   localparam logic [2:0] START_CODE_LAST = 3'd3;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_R_SKIP     = 4'd1,
      PH_R_HDR      = 4'd2,
      PH_R_SPS_NEXT = 4'd3,
      PH_R_SPS_LO   = 4'd4,
      PH_R_SPS_PAY  = 4'd5,
      PH_R_PPS_NEXT = 4'd6,
      PH_R_PPS_LO   = 4'd7,
      PH_R_PPS_PAY  = 4'd8,
      PH_S_PASS     = 4'd9,
      PH_S_HDR      = 4'd10,
      PH_S_PAY      = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_START = 2'd1,
      OP_MARK  = 2'd2
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       last;
   } cmd_type;

endpackage

>>> rtl/a2b_front.sv
module a2b_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [7:0]                          req_in_byte,
   input  logic [a2b_pkg::UNIT_COUNT_BITS-1:0] req_bytes_left,
   input  logic                                queue_full,
   output logic                                push,
   output a2b_pkg::cmd_type                    push_cmd
);
   import a2b_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  hp_ff, hp_in;
   logic [7:0]  total_ff, total_in;
   logic [7:0]  done_ff, done_in;
   logic [7:0]  saved_ff, saved_in;
   logic [31:0] len_ff, len_in;
   logic        conv_ff, conv_in;

   logic                       accept;
   logic                       is_record;
   logic [UNIT_COUNT_BITS-1:0] left;
   logic                       last_byte;
   logic                       rec_phase;
   phase_type                  eph;
   phase_type                  wph;
   logic [2:0]                 hp_w;
   logic [31:0]                len_w;
   logic [31:0]                len_dec;
   logic [31:0]                len_shift;
   logic [2:0]                 hp_inc;
   logic [15:0]                payload;
   logic                       fits;
   logic                       room;
   logic                       emit_start;
   logic                       emit_byte;
   logic [7:0]                 emit_data;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign is_record = !req_type;
   assign left      = (req_bytes_left == '0) ? UNIT_COUNT_BITS'(1) : req_bytes_left;
   assign last_byte = (left == UNIT_COUNT_BITS'(1));
   assign room      = (left >= UNIT_COUNT_BITS'(2));

   assign rec_phase = phase_ff inside {PH_R_SKIP, PH_R_HDR, PH_R_SPS_NEXT, PH_R_SPS_LO,
                                       PH_R_SPS_PAY, PH_R_PPS_NEXT, PH_R_PPS_LO,
                                       PH_R_PPS_PAY};

   // a kind change abandons the unit in progress
   assign eph = (phase_ff != PH_IDLE && rec_phase != is_record) ? PH_IDLE : phase_ff;

   // a sample unit starts straight in its first working phase
   always_comb begin
      wph   = eph;
      hp_w  = hp_ff;
      len_w = len_ff;
      if (eph == PH_IDLE && !is_record) begin
         wph   = conv_ff ? PH_S_HDR : PH_S_PASS;
         hp_w  = '0;
         len_w = '0;
      end
   end

   assign len_dec   = len_w - 32'd1;
   assign len_shift = {len_w[23:0], req_in_byte};
   assign hp_inc    = hp_w + 3'd1;
   assign payload   = {saved_ff, req_in_byte};
   assign fits      = (UNIT_COUNT_BITS'(payload) <= left - UNIT_COUNT_BITS'(1));

   // next state
   always_comb begin
      phase_in = phase_ff;
      hp_in    = hp_ff;
      total_in = total_ff;
      done_in  = done_ff;
      saved_in = saved_ff;
      len_in   = len_ff;
      conv_in  = conv_ff;
      if (accept) begin
         if (eph == PH_IDLE && is_record) begin
            hp_in = '0;
            if (left < UNIT_COUNT_BITS'(RECORD_MIN_LEN) || req_in_byte != RECORD_VERSION) begin
               phase_in = PH_R_SKIP;
            end else begin
               phase_in = PH_R_HDR;
               hp_in    = 3'd1;
            end
         end else begin
            phase_in = wph;
            hp_in    = hp_w;
            len_in   = len_w;
            unique case (wph)
               PH_R_HDR: begin
                  if (hp_w >= HDR_COUNT_POS) begin
                     total_in = req_in_byte & SPS_COUNT_MASK;
                     done_in  = '0;
                     phase_in = PH_R_SPS_NEXT;
                  end else begin
                     hp_in = hp_inc;
                  end
               end
               PH_R_SPS_NEXT: begin
                  if (done_ff < total_ff && room) begin
                     saved_in = req_in_byte;
                     phase_in = PH_R_SPS_LO;
                  end else begin
                     // this byte is the pps count
                     total_in = req_in_byte;
                     done_in  = '0;
                     conv_in  = 1'b1;
                     phase_in = PH_R_PPS_NEXT;
                  end
               end
               PH_R_SPS_LO, PH_R_PPS_LO: begin
                  if (fits) begin
                     done_in  = done_ff + 8'd1;
                     len_in   = {16'd0, payload};
                     if (payload != '0) begin
                        phase_in = (wph == PH_R_SPS_LO) ? PH_R_SPS_PAY : PH_R_PPS_PAY;
                     end else begin
                        phase_in = (wph == PH_R_SPS_LO) ? PH_R_SPS_NEXT : PH_R_PPS_NEXT;
                     end
                  end else if (wph == PH_R_SPS_LO) begin
                     // truncated sps: its high length byte becomes the pps count
                     total_in = saved_ff;
                     done_in  = '0;
                     conv_in  = 1'b1;
                     if (saved_ff != '0 && room) begin
                        saved_in = req_in_byte;
                        phase_in = PH_R_PPS_LO;
                     end else begin
                        phase_in = PH_R_SKIP;
                     end
                  end else begin
                     phase_in = PH_R_SKIP;
                  end
               end
               PH_R_SPS_PAY, PH_R_PPS_PAY: begin
                  len_in = len_dec;
                  if (len_dec == '0) begin
                     phase_in = (wph == PH_R_SPS_PAY) ? PH_R_SPS_NEXT : PH_R_PPS_NEXT;
                  end
               end
               PH_R_PPS_NEXT: begin
                  if (done_ff < total_ff && room) begin
                     saved_in = req_in_byte;
                     phase_in = PH_R_PPS_LO;
                  end else begin
                     phase_in = PH_R_SKIP;
                  end
               end
               PH_S_HDR: begin
                  len_in = len_shift;
                  hp_in  = hp_inc;
                  if (hp_inc >= LEN_FIELD_BYTES) begin
                     hp_in = '0;
                     if (len_shift != '0) begin
                        phase_in = PH_S_PAY;
                     end
                  end
               end
               PH_S_PAY: begin
                  len_in = len_dec;
                  if (len_dec == '0) begin
                     hp_in    = '0;
                     phase_in = PH_S_HDR;
                  end
               end
               default: begin
               end
            endcase
         end
         if (last_byte) begin
            phase_in = PH_IDLE;
            hp_in    = '0;
         end
      end
   end

   // outputs
   always_comb begin
      emit_start = 1'b0;
      emit_byte  = 1'b0;
      emit_data  = req_in_byte;
      unique case (wph)
         PH_R_SPS_LO, PH_R_PPS_LO: begin
            emit_start = fits;
         end
         PH_R_SPS_PAY, PH_R_PPS_PAY, PH_S_PASS, PH_S_PAY: begin
            emit_byte = 1'b1;
         end
         PH_S_HDR: begin
            emit_byte = 1'b1;
            emit_data = (hp_w >= START_CODE_LAST) ? 8'd1 : 8'd0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      push_cmd.last = last_byte;
      push_cmd.data = emit_data;
      if (emit_start) begin
         push_cmd.op = OP_START;
      end else if (emit_byte) begin
         push_cmd.op = OP_BYTE;
      end else begin
         push_cmd.op   = OP_MARK;
         push_cmd.data = '0;
      end
   end

   assign push = accept && (emit_start || emit_byte || last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hp_ff    <= '0;
         total_ff <= '0;
         done_ff  <= '0;
         saved_ff <= '0;
         len_ff   <= '0;
         conv_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         hp_ff    <= hp_in;
         total_ff <= total_in;
         done_ff  <= done_in;
         saved_ff <= saved_in;
         len_ff   <= len_in;
         conv_ff  <= conv_in;
      end
   end

endmodule

>>> rtl/a2b_queue.sv
module a2b_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  a2b_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output a2b_pkg::cmd_type head_cmd
);
   import a2b_pkg::*;

   cmd_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0] rd_ff, rd_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign full       = (cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_cmd   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in  = do_push ? wr_ff + QUEUE_PTR_W'(1) : wr_ff;
      rd_in  = do_pop ? rd_ff + QUEUE_PTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/a2b_back.sv
module a2b_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  a2b_pkg::cmd_type head_cmd,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_byte_valid,
   output logic             rsp_unit_last
);
   import a2b_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       last_ff, last_in;
   logic [1:0] sub_ff, sub_in;
   logic       load;
   logic       sub_end;

   assign load    = !valid_ff || rsp_ready;
   assign sub_end = (sub_ff == 2'd3);

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      bv_in    = bv_ff;
      last_in  = last_ff;
      sub_in   = sub_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            case (head_cmd.op)
               OP_START: begin
                  // start code goes out over four words
                  byte_in = sub_end ? 8'd1 : 8'd0;
                  bv_in   = 1'b1;
                  last_in = head_cmd.last && sub_end;
                  sub_in  = sub_ff + 2'd1;
                  pop     = sub_end;
               end
               OP_MARK: begin
                  byte_in = '0;
                  bv_in   = 1'b0;
                  last_in = head_cmd.last;
                  pop     = 1'b1;
               end
               default: begin
                  byte_in = head_cmd.data;
                  bv_in   = 1'b1;
                  last_in = head_cmd.last;
                  pop     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bv_ff   <= bv_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_byte_valid = bv_ff;
   assign rsp_unit_last  = last_ff;

endmodule

>>> rtl/avcc_to_annexb_converter.sv
// h.264 length-prefixed (avcc) to start-code (annex b) converter, one byte a word.
// a parser at the front takes one input byte a cycle whenever the four-entry
// command queue has room, and turns it into at most one command: pass a byte,
// send a start code, or mark the end of a unit that gave nothing. the expander
// at the back turns each command into output words through a registered output
// stage, one word a cycle while the receiver is ready; a start code gives four
// words, any other command one. the sustained rate is therefore one byte a cycle
// through payload and passthrough runs, and an input byte that opens a start code
// costs four output words, absorbed by the queue while output words keep flowing.
// a configuration record (req_type 0) that reaches its pps count enables
// length rewriting for later sample units (req_type 1); until then sample bytes
// pass unchanged. req_bytes_left of one (or zero) marks the end of a unit.
module avcc_to_annexb_converter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [7:0]                          req_in_byte,
   input  logic [a2b_pkg::UNIT_COUNT_BITS-1:0] req_bytes_left,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_unit_last
);
   import a2b_pkg::*;

   // parser to queue
   logic    push;
   cmd_type push_cmd;
   logic    queue_full;

   // queue to expander
   logic    pop;
   logic    head_valid;
   cmd_type head_cmd;

   // front: unit tracking and record / sample parsing
   a2b_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_in_byte    (req_in_byte),
      .req_bytes_left (req_bytes_left),
      .queue_full     (queue_full),
      .push           (push),
      .push_cmd       (push_cmd)
   );

   // short queue so each side can stall on its own
   a2b_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: command expansion and output register
   a2b_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_unit_last  (rsp_unit_last)
   );

endmodule

>>> sim/tb_avcc_to_annexb_converter.sv
`timescale 1ns / 1ps

module tb_avcc_to_annexb_converter;
   import a2b_pkg::*;

   // unit kinds on req_type
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_SAMPLE = 1'b1;

   // cycles allowed for the parser, command queue and output stage to settle
   localparam int DRAIN_CYCLES = 16;
   // random stimulus stops once this many words have gone in
   localparam int RANDOM_WORDS = 100;
   // hard stop for a hung run, in ns
   localparam int RUN_LIMIT_NS = 5_000_000;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       unit_last;
   } annexb_word_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_type = KIND_RECORD;
   logic [7:0]                 req_in_byte = '0;
   logic [UNIT_COUNT_BITS-1:0] req_bytes_left = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [7:0]                 rsp_out_byte;
   logic                       rsp_byte_valid;
   logic                       rsp_unit_last;

   // words the converter still owes us, oldest first
   annexb_word_type expected_words[$];
   // bytes of the unit being built for the sender
   logic [7:0]      unit_bytes[$];

   int fail_count = 0;
   int words_sent = 0;
   int words_this_byte;

   // idling controls, both sides
   logic tx_idle_en  = 1'b1;
   logic rx_stall_en = 1'b1;
   int   rx_hold     = 0;

   // shadow of the converter's parse state
   phase_type   cur_phase  = PH_IDLE;
   logic [2:0]  hdr_count  = '0;
   logic [7:0]  nals_wanted = '0;
   logic [7:0]  nals_seen  = '0;
   logic [7:0]  len_hi     = '0;
   logic [31:0] remain     = '0;
   logic        annexb_on  = 1'b0;

   avcc_to_annexb_converter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_in_byte    (req_in_byte),
      .req_bytes_left (req_bytes_left),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_unit_last  (rsp_unit_last)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // expected stream
   // ------------------------------------------------------------------

   function automatic void push_word(logic [7:0] b, logic v);
      annexb_word_type w;
      w.out_byte   = b;
      w.byte_valid = v;
      w.unit_last  = 1'b0;
      expected_words.push_back(w);
      words_this_byte++;
   endfunction

   function automatic void push_start_code();
      push_word(8'h00, 1'b1);
      push_word(8'h00, 1'b1);
      push_word(8'h00, 1'b1);
      push_word(8'h01, 1'b1);
   endfunction

   // pps count seen: conversion is armed from here on
   function automatic void arm_pps(logic [7:0] cnt);
      nals_wanted = cnt;
      nals_seen   = '0;
      annexb_on   = 1'b1;
      cur_phase   = PH_R_PPS_NEXT;
   endfunction

   function automatic void pps_step(logic [7:0] b, logic [31:0] left);
      if (nals_seen < nals_wanted && left >= 32'd2) begin
         len_hi    = b;
         cur_phase = PH_R_PPS_LO;
      end else begin
         cur_phase = PH_R_SKIP;
      end
   endfunction

   // low length byte of a record nal; a nal running past the record is dropped
   function automatic bit record_nal_fits(logic [7:0] b, logic [31:0] left,
                                          phase_type pay_ph, phase_type next_ph);
      logic [31:0] nal_len;
      nal_len = {16'h0000, len_hi, b};
      if (nal_len > left - 32'd1) return 1'b0;
      push_start_code();
      nals_seen = nals_seen + 8'd1;
      remain    = nal_len;
      if (nal_len != 0) cur_phase = pay_ph;
      else cur_phase = next_ph;
      return 1'b1;
   endfunction

   // works out every word that one accepted input byte gives
   function automatic void predict_annexb(logic kind, logic [7:0] b,
                                          logic [UNIT_COUNT_BITS-1:0] bytes_left);
      logic [31:0]     left;
      logic            is_record;
      logic            header_only;
      annexb_word_type w;
      left        = 32'(bytes_left);
      is_record   = (kind == KIND_RECORD);
      header_only = 1'b0;
      words_this_byte = 0;
      if (left == 0) left = 32'd1;

      // a change of kind abandons the unit in progress
      if (cur_phase != PH_IDLE && ((cur_phase <= PH_R_PPS_PAY) != is_record))
         cur_phase = PH_IDLE;

      if (cur_phase == PH_IDLE) begin
         hdr_count = '0;
         if (is_record) begin
            header_only = 1'b1;
            if (left < RECORD_MIN_LEN || b != RECORD_VERSION) begin
               cur_phase = PH_R_SKIP;
            end else begin
               cur_phase = PH_R_HDR;
               hdr_count = 3'd1;
            end
         end else begin
            remain = '0;
            if (annexb_on) cur_phase = PH_S_HDR;
            else cur_phase = PH_S_PASS;
         end
      end

      if (!header_only) begin
         case (cur_phase)
            PH_R_HDR: begin
               if (hdr_count >= HDR_COUNT_POS) begin
                  nals_wanted = b & SPS_COUNT_MASK;
                  nals_seen   = '0;
                  cur_phase   = PH_R_SPS_NEXT;
               end else begin
                  hdr_count = hdr_count + 3'd1;
               end
            end
            PH_R_SPS_NEXT: begin
               if (nals_seen < nals_wanted && left >= 32'd2) begin
                  len_hi    = b;
                  cur_phase = PH_R_SPS_LO;
               end else begin
                  arm_pps(b);
               end
            end
            PH_R_SPS_LO: begin
               // a cut-off sps: its high length byte becomes the pps count
               if (!record_nal_fits(b, left, PH_R_SPS_PAY, PH_R_SPS_NEXT)) begin
                  arm_pps(len_hi);
                  pps_step(b, left);
               end
            end
            PH_R_SPS_PAY, PH_R_PPS_PAY: begin
               push_word(b, 1'b1);
               remain = remain - 32'd1;
               if (remain == 0) begin
                  if (cur_phase == PH_R_SPS_PAY) cur_phase = PH_R_SPS_NEXT;
                  else cur_phase = PH_R_PPS_NEXT;
               end
            end
            PH_R_PPS_NEXT: pps_step(b, left);
            PH_R_PPS_LO: begin
               if (!record_nal_fits(b, left, PH_R_PPS_PAY, PH_R_PPS_NEXT))
                  cur_phase = PH_R_SKIP;
            end
            PH_S_PASS: push_word(b, 1'b1);
            PH_S_HDR: begin
               push_word((hdr_count >= START_CODE_LAST) ? 8'h01 : 8'h00, 1'b1);
               remain    = {remain[23:0], b};
               hdr_count = hdr_count + 3'd1;
               if (hdr_count >= LEN_FIELD_BYTES) begin
                  hdr_count = '0;
                  if (remain != 0) cur_phase = PH_S_PAY;
               end
            end
            PH_S_PAY: begin
               push_word(b, 1'b1);
               remain = remain - 32'd1;
               if (remain == 0) begin
                  hdr_count = '0;
                  cur_phase = PH_S_HDR;
               end
            end
            default: ;
         endcase
      end

      if (left == 32'd1) begin
         // end of unit: a bare marker when the byte gave nothing
         if (words_this_byte == 0) push_word(8'h00, 1'b0);
         w = expected_words.pop_back();
         w.unit_last = 1'b1;
         expected_words.push_back(w);
         cur_phase = PH_IDLE;
         hdr_count = '0;
      end
   endfunction

   // ------------------------------------------------------------------
   // idling
   // ------------------------------------------------------------------

   // mostly short gaps, now and then a long one
   function automatic int gap_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // receiver stalls at random while rx_stall_en is set
   always @(posedge clock) begin
      if (rx_hold != 0) begin
         rx_hold   <= rx_hold - 1;
         rsp_ready <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
         rsp_ready <= 1'b0;
         rx_hold   <= gap_length();
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // result checking: every accepted word against the oldest expectation
   // ------------------------------------------------------------------

   always @(posedge clock) begin : check_words
      annexb_word_type exp_w;
      annexb_word_type got_w;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         got_w.out_byte   = rsp_out_byte;
         got_w.byte_valid = rsp_byte_valid;
         got_w.unit_last  = rsp_unit_last;
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, actual byte %h valid %b last %b",
                     $time, got_w.out_byte, got_w.byte_valid, got_w.unit_last);
            fail_count++;
         end else begin
            exp_w = expected_words.pop_front();
            if (got_w !== exp_w) begin
               $display("%0t: expected byte %h valid %b last %b, actual byte %h valid %b last %b",
                        $time, exp_w.out_byte, exp_w.byte_valid, exp_w.unit_last,
                        got_w.out_byte, got_w.byte_valid, got_w.unit_last);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------

   // offers one word and returns at the edge where it was taken; valid is
   // left high so that a back-to-back word does not drop it for a cycle
   task automatic send_byte(input logic kind, input logic [7:0] b,
                            input logic [UNIT_COUNT_BITS-1:0] bytes_left);
      int gap;
      gap = tx_idle_en ? gap_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_in_byte    <= b;
      req_bytes_left <= bytes_left;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_annexb(kind, b, bytes_left);
      words_sent++;
   endtask

   // sends unit_bytes as one unit; a non-zero pad keeps the unit open
   task automatic send_unit(input logic kind, input logic [UNIT_COUNT_BITS-1:0] pad);
      int i;
      for (i = 0; i < unit_bytes.size(); i++)
         send_byte(kind, unit_bytes[i], UNIT_COUNT_BITS'(unit_bytes.size() - i) + pad);
   endtask

   // sender holds off until the converter has delivered everything owed
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // record: version, four ignored bytes, sps count, sps nals, pps count, pps nals
   task automatic build_record(input int sps_n, input int pps_n, input int max_len);
      int i;
      int j;
      int len;
      unit_bytes.delete();
      unit_bytes.push_back(RECORD_VERSION);
      repeat (4) unit_bytes.push_back(8'($urandom));
      unit_bytes.push_back({3'($urandom_range(0, 7)), 5'(sps_n)});
      for (i = 0; i < sps_n + pps_n; i++) begin
         if (i == sps_n) unit_bytes.push_back(8'(pps_n));
         len = $urandom_range(0, max_len);
         unit_bytes.push_back(8'(len >> 8));
         unit_bytes.push_back(8'(len));
         for (j = 0; j < len; j++) unit_bytes.push_back(8'($urandom));
      end
      if (pps_n == 0) unit_bytes.push_back(8'h00);
   endtask

   // sample: nals each behind a four byte big-endian length
   task automatic build_sample(input int nal_n, input int max_len);
      int i;
      int j;
      int len;
      unit_bytes.delete();
      for (i = 0; i < nal_n; i++) begin
         len = $urandom_range(0, max_len);
         unit_bytes.push_back(8'(len >> 24));
         unit_bytes.push_back(8'(len >> 16));
         unit_bytes.push_back(8'(len >> 8));
         unit_bytes.push_back(8'(len));
         for (j = 0; j < len; j++) unit_bytes.push_back(8'($urandom));
      end
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // nothing armed yet: sample bytes come straight through
   task automatic test_passthrough_unarmed();
      unit_bytes = '{8'h00, 8'hff};
      send_unit(KIND_SAMPLE, '0);
      // zero bytes left closes the unit just like one
      send_byte(KIND_SAMPLE, 8'h3c, '0);
      wait_drained();
   endtask

   // records that must leave conversion off
   task automatic test_rejected_records();
      // too short: only a bare end marker
      unit_bytes = '{RECORD_VERSION};
      send_unit(KIND_RECORD, '0);
      // one empty sps that ends the record: start code out, but no pps count
      // byte left, so conversion stays off (upper count bits are masked)
      unit_bytes = '{RECORD_VERSION, 8'haa, 8'hbb, 8'hcc, 8'hdd, 8'he1, 8'h00, 8'h00};
      send_unit(KIND_RECORD, '0);
      // wrong version on a huge record, then a sample byte abandons it and
      // must still pass through unchanged
      send_byte(KIND_RECORD, 8'h02, '1);
      send_byte(KIND_SAMPLE, 8'h5a, 1);
      wait_drained();
   endtask

   // cut-off sps makes its high length byte the pps count, then a cut-off
   // pps ends the parse; conversion is armed
   task automatic test_truncated_record();
      unit_bytes = '{RECORD_VERSION, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
                     8'h01, 8'h05, 8'h07};
      send_unit(KIND_RECORD, '0);
      wait_drained();
   endtask

   // armed: lengths become start codes
   task automatic test_sample_rewrite();
      // one-byte nal, then a length field cut off by the end of the unit
      unit_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'hc3, 8'h00, 8'h00};
      send_unit(KIND_SAMPLE, '0);
      // length larger than the unit: payload runs to the end
      unit_bytes = '{8'h00, 8'h00, 8'h00, 8'hff, 8'hab};
      send_unit(KIND_SAMPLE, '0);
      wait_drained();
   endtask

   // mostly well-formed records and samples, some broken units and noise
   task automatic test_random_traffic();
      int   pick;
      int   cut;
      logic kind;
      while (words_sent < RANDOM_WORDS) begin
         // quiet stretches with no idling on either side
         if ($urandom_range(0, 3) == 0) begin
            tx_idle_en  = 1'b0;
            rx_stall_en <= 1'b0;
         end else begin
            tx_idle_en  = 1'b1;
            rx_stall_en <= 1'b1;
         end
         pick = $urandom_range(0, 9);
         kind = ($urandom_range(0, 1) == 0) ? KIND_RECORD : KIND_SAMPLE;
         if (pick <= 1 || (pick >= 7 && pick <= 8 && kind == KIND_RECORD))
            build_record($urandom_range(0, 2), $urandom_range(0, 2), 4);
         else
            build_sample($urandom_range(1, 3), 6);
         if (pick <= 1 || (pick >= 7 && pick <= 8 && kind == KIND_RECORD))
            kind = KIND_RECORD;
         else
            kind = KIND_SAMPLE;
         case (pick)
            7: begin
               if ($urandom_range(0, 1) == 0) begin
                  // unit cut short
                  cut = $urandom_range(1, unit_bytes.size());
                  while (unit_bytes.size() > cut) void'(unit_bytes.pop_back());
                  send_unit(kind, '0);
               end else begin
                  // unit that claims to run on; a kind change abandons it
                  send_unit(kind, UNIT_COUNT_BITS'($urandom_range(1, 24'hfff000)));
               end
            end
            8: begin
               // one corrupted byte anywhere, the version byte included
               unit_bytes[$urandom_range(0, unit_bytes.size() - 1)] = 8'($urandom);
               send_unit(kind, '0);
            end
            9: begin
               repeat ($urandom_range(1, 4))
                  send_byte(($urandom_range(0, 1) == 0) ? KIND_RECORD : KIND_SAMPLE,
                            8'($urandom),
                            ($urandom_range(0, 1) == 0)
                               ? UNIT_COUNT_BITS'($urandom_range(0, 3))
                               : UNIT_COUNT_BITS'($urandom));
            end
            default: send_unit(kind, '0);
         endcase
         // now and then let everything drain before going on
         if ($urandom_range(0, 9) == 0) wait_drained();
      end
      tx_idle_en  = 1'b1;
      rx_stall_en <= 1'b1;
      wait_drained();
   endtask

   // ------------------------------------------------------------------
   // run
   // ------------------------------------------------------------------

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_passthrough_unarmed();
      test_rejected_records();
      test_truncated_record();
      test_sample_rewrite();
      test_random_traffic();
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // hung run guard
   initial begin
      #(RUN_LIMIT_NS);
      $display("== FAIL ==");
      $finish;
   end

endmodule
